// File: src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/mcal_pkg.sv
`timescale 1ns / 1ps

package mcal_pkg;

  // width of readings and anchors
  localparam int SAMPLE_BITS = 16;

  // moisture result width and full scale in tenths of a percent
  localparam int MOIST_W = 10;
  localparam logic [MOIST_W-1:0] FULL_SCALE = 10'd1000;

  // quotient bits produced by the serial divider, one per step
  localparam int QBITS = MOIST_W;
  localparam int CNT_W = $clog2(QBITS + 1);

  // scaled numerator width: diff times 1000 fits below diff shifted by ten
  localparam int NUMER_W = SAMPLE_BITS + QBITS;

  // operation codes, any other code acts as a sample
  localparam logic [1:0] OP_SAMPLE      = 2'd0;
  localparam logic [1:0] OP_CAPTURE_DRY = 2'd1;
  localparam logic [1:0] OP_CAPTURE_WET = 2'd2;

  // divider request and response
  typedef struct packed {
    logic                   start;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] span;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QBITS-1:0] quotient;
  } div_resp_t;

endpackage

// File: src/mcal_div.sv
`timescale 1ns / 1ps

module mcal_div (
  input  logic                clk,
  input  logic                rst,
  input  mcal_pkg::div_req_t  req,
  output mcal_pkg::div_resp_t resp
);

  logic                             busy;
  logic                             loaded;
  logic                             done;
  logic [mcal_pkg::CNT_W-1:0]       cnt;
  logic [mcal_pkg::SAMPLE_BITS-1:0] dreg;
  logic [mcal_pkg::SAMPLE_BITS-1:0] sreg;
  logic [mcal_pkg::SAMPLE_BITS-1:0] rem;
  logic [mcal_pkg::QBITS-1:0]       quo;

  logic [mcal_pkg::NUMER_W-1:0]     numer;
  logic [mcal_pkg::SAMPLE_BITS:0]   trial;
  logic                             qbit;
  logic [mcal_pkg::SAMPLE_BITS-1:0] rem_next;

  // diff times 1000 as 1024 - 16 - 8
  always_comb begin
    numer = ({dreg, mcal_pkg::QBITS'(0)})
          - mcal_pkg::NUMER_W'({dreg, 4'b0})
          - mcal_pkg::NUMER_W'({dreg, 3'b0});
  end

  // one restoring step: shift in the next numerator bit, try the span
  always_comb begin
    trial = {rem, quo[mcal_pkg::QBITS-1]};
    qbit  = (trial >= {1'b0, sreg});
    if (qbit) begin
      rem_next = mcal_pkg::SAMPLE_BITS'(trial - {1'b0, sreg});
    end else begin
      rem_next = trial[mcal_pkg::SAMPLE_BITS-1:0];
    end
  end

  // operand load, scale cycle, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      loaded <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        loaded <= 1'b0;
        dreg   <= req.diff;
        sreg   <= req.span;
      end else if (busy && !loaded) begin
        rem    <= numer[mcal_pkg::NUMER_W-1:mcal_pkg::QBITS];
        quo    <= numer[mcal_pkg::QBITS-1:0];
        cnt    <= mcal_pkg::CNT_W'(mcal_pkg::QBITS);
        loaded <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[mcal_pkg::QBITS-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == mcal_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.busy     = busy;
  assign resp.done     = done;
  assign resp.quotient = quo;

endmodule

// File: src/two_point_moisture_calibration.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Two-point moisture calibration. Each input beat carries an operation and a
// millivolt reading: a capture stores the reading as the dry or the wet anchor,
// a sample reports moisture in tenths of a percent, linear between the anchors
// (a wetter probe reads lower) and clamped to 0..1000. Every beat gives one
// result beat with the echoed reading and a calibrated flag that is set when
// both anchors are nonzero and dry exceeds wet. Captures and samples that need
// no division pass from acceptance through the emit state into the output
// register; an in-range sample first passes through the bit-serial restoring
// divider (operand load, a scale step, then one quotient bit per step, with the
// done pulse handing the quotient to the emit state). One beat is in flight at a
// time, and a finished result waits in the output register while the next beat
// enters; a stalled output holds the next beat in the emit state.

module two_point_moisture_calibration (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] reading_mv,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] raw_mv,
  output logic [mcal_pkg::MOIST_W-1:0] moisture_tenths,
  output logic        calibrated
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                           state;
  logic [mcal_pkg::SAMPLE_BITS-1:0] dry_anchor;
  logic [mcal_pkg::SAMPLE_BITS-1:0] wet_anchor;
  logic [mcal_pkg::SAMPLE_BITS-1:0] held_mv;
  logic [mcal_pkg::MOIST_W-1:0]     held_moist;

  logic                             accept;
  logic                             is_sample;
  logic [mcal_pkg::SAMPLE_BITS-1:0] mv;
  logic                             cal_now;
  logic                             below_dry;
  logic [mcal_pkg::SAMPLE_BITS-1:0] diff;
  logic [mcal_pkg::SAMPLE_BITS-1:0] span;
  logic                             saturate;
  logic                             need_div;
  logic [mcal_pkg::MOIST_W-1:0]     quick_moist;
  logic                             out_free;

  mcal_pkg::div_req_t               dreq;
  mcal_pkg::div_resp_t              dresp;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // decode the incoming beat against the current anchors
  always_comb begin
    mv        = reading_mv[mcal_pkg::SAMPLE_BITS-1:0];
    is_sample = (operation != mcal_pkg::OP_CAPTURE_DRY) &&
                (operation != mcal_pkg::OP_CAPTURE_WET);
    cal_now   = (dry_anchor != '0) && (wet_anchor != '0) && (dry_anchor > wet_anchor);
    below_dry = (mv < dry_anchor);
    diff      = dry_anchor - mv;
    span      = dry_anchor - wet_anchor;
    saturate  = (diff >= span);
    need_div  = is_sample && cal_now && below_dry && !saturate;
    if (is_sample && cal_now && below_dry && saturate) begin
      quick_moist = mcal_pkg::FULL_SCALE;
    end else begin
      quick_moist = '0;
    end
  end

  assign dreq.start = accept && need_div;
  assign dreq.diff  = diff;
  assign dreq.span  = span;

  mcal_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .resp (dresp)
  );

  // sequencer, anchors and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dry_anchor <= '0;
      wet_anchor <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            held_mv    <= mv;
            held_moist <= quick_moist;
            if (operation == mcal_pkg::OP_CAPTURE_DRY) begin
              dry_anchor <= mv;
            end else if (operation == mcal_pkg::OP_CAPTURE_WET) begin
              wet_anchor <= mv;
            end
            state <= need_div ? S_DIV : S_EMIT;
          end
        end
        S_DIV: begin
          if (dresp.done) begin
            held_moist <= dresp.quotient;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            raw_mv          <= 16'(held_mv);
            moisture_tenths <= held_moist;
            calibrated      <= cal_now;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // divider finishes only while the sequencer waits on it
  `ASSERT_IMPLY(a_done_in_div, clk, rst, dresp.done, state == S_DIV)
  // a divide is never started while one is still running
  `ASSERT_IMPLY(a_start_idle, clk, rst, dreq.start, !dresp.busy)
  // nonzero moisture only comes with valid calibration and stays within full scale
  `ASSERT_IMPLY(a_moist_cal, clk, rst,
                out_valid && (moisture_tenths != '0),
                calibrated && (moisture_tenths <= mcal_pkg::FULL_SCALE))

endmodule
